### rtl/mps_pkg.sv
// Package for the maze path search block: codes and types.
package mps_pkg;
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    localparam logic [2:0] ST_WRITTEN   = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_NO_PATH   = 3'd2;
    localparam logic [2:0] ST_NO_FURTHER = 3'd3;
    localparam logic [2:0] ST_BEYOND    = 3'd4;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_LEFT  = 3'd1;
    localparam logic [2:0] DIR_RIGHT = 3'd2;
    localparam logic [2:0] DIR_UP    = 3'd3;
    localparam logic [2:0] DIR_DOWN  = 3'd4;

    localparam logic [1:0] MARK_OPEN    = 2'd0;
    localparam logic [1:0] MARK_WALL    = 2'd1;
    localparam logic [1:0] MARK_VISITED = 2'd2;
    localparam logic [1:0] MARK_DEAD    = 2'd3;

    localparam int unsigned REG_ROWS = 0;
    localparam int unsigned REG_COLS = 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,     // read top entry for pop on a follow-up search
        S_POP_WAIT,
        S_TOP,        // top entry read data available
        S_PROBE,      // neighbor mark read issued
        S_PROBE_CHK,  // neighbor mark available
        S_READ_WAIT,
        S_OUT
    } t_state;
endpackage

### rtl/mps_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module mps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/maze_path_search_dfs_top.sv
// Top level of the depth-first maze path search block.
// Usage:
//  Slave stream carries one command per transaction: write cell, search, or read step.
//  Master stream returns exactly one result per command.
//  Config port sets rows_used (index 0) and cols_used (index 1), clamped to 2..MAX.
// Sequencing:
//  A write or an unused command passes through S_OUT into the output register; a read
//  first passes through S_READ_WAIT for the registered stack RAM read.
//  A search pushes through S_PROBE, S_PROBE_CHK, S_POP_WAIT and S_TOP; a rejected probe
//  returns to S_PROBE, a backtrack goes to S_TOP, and a follow-up search pops in S_POP_RD.
//  One command is in work at a time; the next one is taken once the current one has
//  moved into the output register.
// Reset:
//  Synchronous active-low reset empties the stack and clears the searched flag.
//  The maze memory is not cleared: every cell must be written before a search.
// Stall:
//  While o_m_tvalid is held and i_m_tready is low, one further command may be taken;
//  once finished it waits in its last state and no command after it is accepted.
module maze_path_search_dfs_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: cmd[1:0], cell_row[7:2], cell_col[13:8], wall[14], step_index[26:15]
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: status[2:0], path_length[15:3], step_row[21:16], step_col[27:22],
    //        step_dir[30:28], last_step[31]
    output logic [31:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_wdata
);
    import mps_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DW    = AW + 1;
    localparam int SW    = RW + CW + 3;

    t_state r_state, n_state;
    logic [8:0] r_rows, r_cols;
    logic [DW-1:0] r_depth, n_depth;
    logic r_once, n_once, r_first, n_first;
    logic [2:0] r_status, n_status;
    logic [RW-1:0] r_a, n_a, r_nr, n_nr;
    logic [CW-1:0] r_b, n_b, r_nc, n_nc;
    logic [2:0] r_pdir, n_pdir;
    logic [5:0] r_orow, n_orow, r_ocol, n_ocol;
    logic [2:0] r_odir, n_odir;
    logic r_olast, n_olast, r_ovalid, n_ovalid;
    logic [31:0] r_mdata, n_mdata;
    logic r_push_pend;

    logic m_we, s_we;
    logic [AW-1:0] m_waddr, m_raddr, s_waddr, s_raddr;
    logic [1:0] m_wdata, m_rdata;
    logic [SW-1:0] s_wdata, s_rdata;

    mps_ram #(.WIDTH(2), .DEPTH(CELLS)) u_mark (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );
    mps_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    t_cmd          in_cmd;
    logic [5:0]    in_row, in_col;
    logic          in_wall;
    logic [11:0]   in_idx;
    assign in_cmd  = t_cmd'(i_s_tdata[1:0]);
    assign in_row  = i_s_tdata[7:2];
    assign in_col  = i_s_tdata[13:8];
    assign in_wall = i_s_tdata[14];
    assign in_idx  = i_s_tdata[26:15];

    logic [8:0] cfg_clamp;
    always_comb begin
        cfg_clamp = {2'b00, i_cfg_wdata};
        if (cfg_clamp < 9'd2) cfg_clamp = 9'd2;
        if (i_cfg_index == 1'b0) begin
            if (cfg_clamp > 9'(MAX_ROWS)) cfg_clamp = 9'(MAX_ROWS);
        end else begin
            if (cfg_clamp > 9'(MAX_COLS)) cfg_clamp = 9'(MAX_COLS);
        end
    end

    function automatic logic [AW-1:0] addr_of(logic [RW-1:0] r, logic [CW-1:0] c);
        logic [AW:0] v;
        v = (AW+1)'(r) * (AW+1)'(MAX_COLS) + (AW+1)'(c);
        return v[AW-1:0];
    endfunction

    // a freshly pushed top is written in the wait cycle; take it from r_a/r_b
    logic [RW-1:0] top_r;
    logic [CW-1:0] top_c;
    logic [2:0]    exit_dir;
    assign top_r = r_push_pend ? r_a : s_rdata[SW-1 -: RW];
    assign top_c = r_push_pend ? r_b : s_rdata[CW+2:3];

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_mdata;

    always_comb begin
        n_state = r_state; n_depth = r_depth; n_once = r_once; n_first = r_first;
        n_status = r_status; n_a = r_a; n_b = r_b; n_nr = r_nr; n_nc = r_nc;
        n_pdir = r_pdir; n_orow = r_orow; n_ocol = r_ocol; n_odir = r_odir;
        n_olast = r_olast; n_ovalid = r_ovalid; n_mdata = r_mdata;
        m_we = 1'b0; m_waddr = '0; m_wdata = MARK_OPEN; m_raddr = addr_of(r_nr, r_nc);
        s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = AW'(r_depth - 1'b1);
        exit_dir = DIR_NONE;
        if (r_ovalid && i_m_tready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && o_s_tready) begin
                    n_orow = '0; n_ocol = '0; n_odir = DIR_NONE; n_olast = 1'b0;
                    unique case (in_cmd)
                        CMD_WRITE: begin
                            if (32'(in_row) < MAX_ROWS && 32'(in_col) < MAX_COLS) begin
                                m_we = 1'b1;
                                m_waddr = addr_of(RW'(in_row), CW'(in_col));
                                m_wdata = {1'b0, in_wall};
                            end
                            n_status = ST_WRITTEN; n_state = S_OUT;
                        end
                        CMD_SEARCH: begin
                            n_once = 1'b1;
                            n_first = !r_once;
                            if (!r_once) begin
                                s_we = 1'b1; s_waddr = '0; s_wdata = '0;
                                m_we = 1'b1; m_waddr = '0; m_wdata = MARK_VISITED;
                                n_depth = DW'(1);
                                n_a = '0; n_b = '0;
                                n_pdir = DIR_NONE;
                                n_nr = '0; n_nc = '0;
                                n_state = S_POP_WAIT;
                            end else if (r_depth == '0) begin
                                n_status = ST_NO_FURTHER; n_state = S_OUT;
                            end else begin
                                s_raddr = AW'(r_depth - 1'b1);
                                n_state = S_POP_RD;
                            end
                        end
                        CMD_READ: begin
                            if (13'(in_idx) < 13'(r_depth)) begin
                                s_raddr = AW'(in_idx);
                                n_olast = (13'(in_idx) + 13'd1 == 13'(r_depth));
                                n_status = ST_OK;
                                n_state = S_READ_WAIT;
                            end else begin
                                n_status = ST_BEYOND; n_state = S_OUT;
                            end
                        end
                        default: begin
                            n_status = ST_WRITTEN; n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                // s_rdata holds the old exit; mark dead and drop it
                m_we = 1'b1; m_waddr = addr_of(top_r, top_c); m_wdata = MARK_DEAD;
                n_depth = r_depth - 1'b1;
                if (r_depth == DW'(1)) begin
                    n_status = ST_NO_FURTHER; n_state = S_OUT;
                end else begin
                    s_raddr = AW'(r_depth - DW'(2));
                    n_state = S_TOP;
                end
            end
            S_POP_WAIT: begin
                // second stack write of a push: the new top entry
                s_we = 1'b1; s_waddr = AW'(r_depth - 1'b1);
                s_wdata = {r_a, r_b, DIR_NONE};
                n_state = S_TOP;
            end
            S_TOP: begin
                n_a = top_r; n_b = top_c;
                if (9'(top_r) == r_rows - 9'd1 || 9'(top_c) == r_cols - 9'd1) begin
                    if (top_r == '0) exit_dir = DIR_UP;
                    else if (9'(top_r) == r_rows - 9'd1) exit_dir = DIR_DOWN;
                    if (top_c == '0) exit_dir = DIR_LEFT;
                    else if (9'(top_c) == r_cols - 9'd1) exit_dir = DIR_RIGHT;
                    s_we = 1'b1; s_waddr = AW'(r_depth - 1'b1);
                    s_wdata = {top_r, top_c, exit_dir};
                    n_status = ST_OK; n_state = S_OUT;
                end else begin
                    n_pdir = DIR_NONE;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                // pick next direction after r_pdir that is inside the grid
                exit_dir = DIR_NONE;
                if (r_depth < DW'(CELLS)) begin
                    if (r_pdir < DIR_LEFT && r_b != '0) begin
                        exit_dir = DIR_LEFT; n_nr = r_a; n_nc = r_b - 1'b1;
                    end else if (r_pdir < DIR_RIGHT && 9'(r_b) + 9'd1 < r_cols) begin
                        exit_dir = DIR_RIGHT; n_nr = r_a; n_nc = r_b + 1'b1;
                    end else if (r_pdir < DIR_UP && r_a != '0) begin
                        exit_dir = DIR_UP; n_nr = r_a - 1'b1; n_nc = r_b;
                    end else if (r_pdir < DIR_DOWN && 9'(r_a) + 9'd1 < r_rows) begin
                        exit_dir = DIR_DOWN; n_nr = r_a + 1'b1; n_nc = r_b;
                    end
                end
                if (exit_dir != DIR_NONE) begin
                    m_raddr = addr_of(n_nr, n_nc);
                    n_pdir = exit_dir;
                    n_state = S_PROBE_CHK;
                end else if (r_depth == DW'(1)) begin
                    n_depth = '0;
                    n_status = r_first ? ST_NO_PATH : ST_NO_FURTHER;
                    n_state = S_OUT;
                end else begin
                    m_we = 1'b1; m_waddr = addr_of(r_a, r_b); m_wdata = MARK_DEAD;
                    n_depth = r_depth - 1'b1;
                    s_raddr = AW'(r_depth - DW'(2));
                    n_state = S_TOP;
                end
            end
            S_PROBE_CHK: begin
                if (m_rdata == MARK_OPEN) begin
                    s_we = 1'b1; s_waddr = AW'(r_depth - 1'b1);
                    s_wdata = {r_a, r_b, r_pdir};
                    m_we = 1'b1; m_waddr = addr_of(r_nr, r_nc); m_wdata = MARK_VISITED;
                    n_a = r_nr; n_b = r_nc;
                    n_depth = r_depth + 1'b1;
                    n_state = S_POP_WAIT;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_READ_WAIT: begin
                n_orow = 6'(s_rdata[SW-1 -: RW]);
                n_ocol = 6'(s_rdata[CW+2:3]);
                n_odir = s_rdata[2:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait here while the output register still holds an unaccepted result
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_mdata = {r_olast, r_odir, r_ocol, r_orow, 13'(r_depth), r_status};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_depth <= '0; r_once <= 1'b0; r_ovalid <= 1'b0;
            r_rows <= 9'(MAX_ROWS < 64 ? MAX_ROWS : 64);
            r_cols <= 9'(MAX_COLS < 64 ? MAX_COLS : 64);
            r_push_pend <= 1'b0;
        end else begin
            r_state <= n_state; r_depth <= n_depth; r_once <= n_once;
            r_ovalid <= n_ovalid;
            r_push_pend <= (r_state == S_POP_WAIT);
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(REG_ROWS)) r_rows <= cfg_clamp;
                else r_cols <= cfg_clamp;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        r_first <= n_first; r_status <= n_status; r_a <= n_a; r_b <= n_b;
        r_nr <= n_nr; r_nc <= n_nc; r_pdir <= n_pdir; r_orow <= n_orow;
        r_ocol <= n_ocol; r_odir <= n_odir; r_olast <= n_olast;
        r_mdata <= n_mdata;
    end
endmodule

### rtl/mps_checker.sv
// Port-level checker for the maze path search block, bound to the top level.
module mps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed under stall");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("command taken while previous one in work");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:0] <= 3'd4)
        else $error("bad status");
    a_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != 3'd1 |-> o_m_tdata[31:16] == 16'd0)
        else $error("step fields set without valid read");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result after reset");
endmodule

bind maze_path_search_dfs_top mps_checker u_chk (.*);
